// ===== rtl/core/lpkv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe key/value table package
// Shared sizes, status codes, payload types and controller interface types.
// ----------------------------------------------------------------------------
package lpkv_pkg;

  localparam int unsigned SLOTS  = 256;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned STAT_W = 3;

  // A new key is refused once count * 4 reaches SLOTS * 3.
  localparam int unsigned LOAD_LIMIT = (SLOTS * 3) / 4;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT     = 3'd0,
    ST_MISS    = 3'd1,
    ST_NEW     = 3'd2,
    ST_UPDATED = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    MODE_LOOKUP = 1'b0,
    MODE_INSERT = 1'b1
  } mode_e;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value_in;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value_out;
    logic [CNT_W-1:0]  occupancy;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic advance;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic empty;
    logic last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/lpkv_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe key/value table controller
// Sequences accept, slot probing and commit of one request at a time.
// ----------------------------------------------------------------------------
module lpkv_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lpkv_pkg::stat_t stat_i,
  output lpkv_pkg::cmd_t  cmd_o
);
  import lpkv_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat_i.hit || stat_i.empty || stat_i.last) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_PROBE: begin
        cmd_o.advance = !(stat_i.hit || stat_i.empty || stat_i.last);
      end
      S_COMMIT: begin
        cmd_o.commit = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/lpkv_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe key/value table datapath
// Slot memories, occupancy marks, probe position, entry count and result register.
// ----------------------------------------------------------------------------
module lpkv_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lpkv_pkg::in_t   in_data_i,
  input  lpkv_pkg::cmd_t  cmd_i,
  output lpkv_pkg::stat_t stat_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lpkv_pkg::out_t  out_data_o
);
  import lpkv_pkg::*;

  localparam logic [CNT_W+1:0] LIMIT_X4 = (CNT_W + 2)'(SLOTS * 3);

  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [VAL_W-1:0] val_mem [SLOTS];

  logic [SLOTS-1:0] used_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic             mode_q;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] steps_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [KEY_W-1:0] rd_key_q;
  logic [VAL_W-1:0] rd_val_q;
  logic             out_valid_q;
  out_t             out_q, out_d;

  logic slot_used, match, at_limit;
  logic wr_key, wr_val;

  always_comb begin
    if (cmd_i.load) begin
      pos_d = in_data_i.key[IDX_W-1:0];
    end else if (cmd_i.advance) begin
      pos_d = (pos_q == IDX_W'(SLOTS - 1)) ? '0 : pos_q + 1'b1;
    end else begin
      pos_d = pos_q;
    end
  end

  assign slot_used = used_q[pos_q];
  assign match     = rd_key_q == key_q;
  assign at_limit  = {2'b00, count_q} << 2 >= LIMIT_X4;

  assign stat_o.hit      = slot_used && match;
  assign stat_o.empty    = !slot_used;
  assign stat_o.last     = steps_q == IDX_W'(SLOTS - 1);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    wr_key  = 1'b0;
    wr_val  = 1'b0;
    count_d = count_q;
    out_d.value_out = '0;
    if (mode_q == MODE_LOOKUP) begin
      if (stat_o.hit) begin
        out_d.status    = ST_HIT;
        out_d.value_out = rd_val_q;
      end else begin
        out_d.status = ST_MISS;
      end
    end else begin
      if (stat_o.hit) begin
        out_d.status = ST_UPDATED;
        wr_val       = cmd_i.commit;
      end else if (stat_o.empty && !at_limit) begin
        out_d.status = ST_NEW;
        wr_key       = cmd_i.commit;
        wr_val       = cmd_i.commit;
        count_d      = count_q + 1'b1;
      end else begin
        out_d.status = ST_FULL;
      end
    end
    out_d.occupancy = count_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_key) begin
      key_mem[pos_q] <= key_q;
    end
    if (wr_val) begin
      val_mem[pos_q] <= val_q;
    end
    rd_key_q <= key_mem[pos_d];
    rd_val_q <= val_mem[pos_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= in_data_i.key;
      val_q  <= in_data_i.value_in;
      mode_q <= in_data_i.mode;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      pos_q       <= '0;
      steps_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (cmd_i.load) begin
        steps_q <= '0;
      end else if (cmd_i.advance) begin
        steps_q <= steps_q + 1'b1;
      end
      if (wr_key) begin
        used_q[pos_q] <= 1'b1;
      end
      if (cmd_i.commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/linear_probe_key_value_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe key/value table
// Fixed-capacity open-addressing store with lookup and insert requests.
// ----------------------------------------------------------------------------
// Requests are taken one at a time: the slots are probed one per cycle through the
// registered slot memories, and the result is then committed to the result register.
// One request is in flight at a time; the next is taken only after the last commits.
// Reset clears all slot occupancy marks and the entry count at once.
module linear_probe_key_value_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lpkv_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lpkv_pkg::out_t out_data_o
);
  import lpkv_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lpkv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lpkv_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/lpkv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe key/value table checker
// Port-level checks on the request and result channels.
// ----------------------------------------------------------------------------
module lpkv_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input lpkv_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input lpkv_pkg::out_t out_data_o
);
  import lpkv_pkg::*;

  // A stalled result beat stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // Only one request is in flight, so an accepted beat blocks the next one.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  // Only a hit carries a nonzero value.
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_HIT |-> out_data_o.value_out == '0)
    else $error("nonzero value on a non-hit result");

  // Occupancy never passes the load limit.
  a_occ_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.occupancy <= CNT_W'(LOAD_LIMIT))
    else $error("occupancy above load limit");

endmodule

bind linear_probe_key_value_table lpkv_checker u_lpkv_checker (.*);
